// File: src/bnf_pkg.sv
// ----------------------------------------------------------------------------
// bnf_pkg: shared definitions of the batch normalization unit
// Sizes, item kinds, result codes and the arithmetic unit request.
// ----------------------------------------------------------------------------
package bnf_pkg;

  localparam int MAX_CHANNELS = 64;
  localparam int BUFFER_DEPTH = 1024;

  localparam int CH_W    = $clog2(MAX_CHANNELS);
  localparam int IDX_W   = $clog2(BUFFER_DEPTH);
  localparam int FILL_W  = $clog2(BUFFER_DEPTH + 1);
  localparam int CNT_W   = FILL_W;
  // Sum of rounded squares: up to 2^48 per sample, one per buffer entry.
  localparam int ACC_W   = 49 + IDX_W;
  localparam int ACCW_W  = CNT_W + ACC_W;
  localparam int ENTRY_W = CH_W + 32;

  // Arithmetic unit sizes.
  localparam int NUM_W    = ACC_W;
  localparam int DEN_W    = 32;
  localparam int SQ_IN_W  = 48;
  localparam int D_W      = SQ_IN_W / 2;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_FINISH = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_LOAD,
    K_STORED,
    K_BATCH,
    K_FINISH,
    K_READ
  } kind_t;

  typedef enum logic [2:0] {
    ST_VALUE    = 3'd0,
    ST_STORED   = 3'd1,
    ST_FINISHED = 3'd2,
    ST_FULL     = 3'd3,
    ST_INVALID  = 3'd4
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [CH_W-1:0]    channel;
    logic [IDX_W-1:0]   buffer_index;
    logic signed [31:0] sample;
    logic signed [31:0] variance;
  } item_t;

  typedef enum logic {
    MOP_DIV,
    MOP_SQRT
  } math_op_t;

  typedef struct packed {
    logic             start;
    math_op_t         op;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } math_req_t;

endpackage

// File: src/batch_norm_forward_unit.sv
// ----------------------------------------------------------------------------
// batch_norm_forward_unit: per-channel batch normalization, Q16.16
// Top level with configuration registers, input queue and sequencer.
// ----------------------------------------------------------------------------
// Usage. Words enter through a queue-style port: a word is taken at a clock
// edge with push high and full low. Results leave the same way: while empty
// is low the oldest result sits on result_value and status, and pop takes it.
// Every input word gives exactly one result word, in order.
// Configuration registers are written through cfg_write, cfg_index and
// cfg_data; write them only while no word is in flight.
// Operation. Words run one at a time through a sequencer that shares a single
// iterative unit: a division runs 59 quotient steps and a square root 24
// steps. A stored-statistics sample uses two scaling divisions, one root and
// one division (no scaling divisions with a zero scale word), a buffered read
// one root and one division, and a finish a mean division per channel holding
// samples, a walk over the buffer and a variance division per such channel;
// the last division of a sample or read is skipped when the root is zero.
// A two-word input queue and one result register let either side stall on its
// own; a waiting result holds the sequencer only when the next result is ready.
// Reset empties both queues and clears the statistics, sums and batch state
// through valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module batch_norm_forward_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                opcode,
  input  logic [bnf_pkg::CH_W-1:0]  channel,
  input  logic [bnf_pkg::IDX_W-1:0] buffer_index,
  input  logic signed [31:0]        sample_value,
  input  logic signed [31:0]        variance_value,
  output logic                      empty,
  input  logic                      pop,
  output logic signed [31:0]        result_value,
  output logic [2:0]                status,
  input  logic                      cfg_write,
  input  logic [1:0]                cfg_index,
  input  logic [31:0]               cfg_data
);
  import bnf_pkg::*;

  // Register indexes of the configuration port.
  localparam logic [1:0] CFG_USE_STORED = 2'd0;
  localparam logic [1:0] CFG_EPSILON    = 2'd1;
  localparam logic [1:0] CFG_SCALE      = 2'd2;

  logic        use_stored_stats;
  logic [15:0] epsilon;
  logic [31:0] stats_scale_word;

  logic        item_valid;
  item_t       item;
  logic        item_pop;
  logic        res_valid;
  logic        res_pop;

  // Configuration registers; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      use_stored_stats <= 1'b1;
      epsilon          <= 16'd1;
      stats_scale_word <= 32'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_USE_STORED: use_stored_stats <= cfg_data[0];
        CFG_EPSILON:    epsilon          <= cfg_data[15:0];
        CFG_SCALE:      stats_scale_word <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The result register is the output queue: it is empty when not valid.
  assign empty   = !res_valid;
  assign res_pop = pop && res_valid;

  // The front end tags each word with its kind using the mode register.
  bnf_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .opcode         (opcode),
    .channel        (channel),
    .buffer_index   (buffer_index),
    .sample_value   (sample_value),
    .variance_value (variance_value),
    .use_stored     (use_stored_stats),
    .item_valid     (item_valid),
    .item           (item),
    .item_pop       (item_pop)
  );

  // The back end owns the tables, the sample buffer and the math unit.
  bnf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .epsilon    (epsilon),
    .scale_word (stats_scale_word),
    .res_valid  (res_valid),
    .res_value  (result_value),
    .res_status (status),
    .res_pop    (res_pop)
  );

endmodule

// File: src/bnf_ram.sv
// ----------------------------------------------------------------------------
// bnf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bnf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/bnf_math.sv
// ----------------------------------------------------------------------------
// bnf_math: shared iterative divider and square root
// Restoring division one quotient bit a cycle; integer root one digit a cycle.
// ----------------------------------------------------------------------------
module bnf_math (
  input  logic                    clk,
  input  logic                    rst,
  input  bnf_pkg::math_req_t      req,
  output logic                    done,
  output logic [bnf_pkg::NUM_W-1:0] quot
);
  import bnf_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);
  localparam int SQ_W   = SQ_IN_W + 1;

  typedef enum logic [1:0] {M_IDLE, M_DIV, M_SQRT} mstate_t;

  mstate_t          state;
  logic [STEP_W-1:0] steps;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [SQ_W-1:0]  sq_v;
  logic [SQ_W-1:0]  sq_r;
  logic [SQ_W-1:0]  sq_bit;

  logic [DEN_W:0]   rem_sh;
  logic             fits;
  logic [DEN_W:0]   rem_nx;
  logic [SQ_W-1:0]  trial;
  logic             take;
  logic [SQ_W-1:0]  sq_r_next;

  assign rem_sh = {rem, num[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den};
  assign rem_nx = fits ? (rem_sh - {1'b0, den}) : rem_sh;

  assign trial     = sq_r + sq_bit;
  assign take      = sq_v >= trial;
  assign sq_r_next = take ? ((sq_r >> 1) + sq_bit) : (sq_r >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (req.start) begin
            if (req.op == MOP_DIV) begin
              state <= M_DIV;
              steps <= STEP_W'(NUM_W);
            end else begin
              state <= M_SQRT;
              steps <= STEP_W'(D_W);
            end
          end
        end
        M_DIV: begin
          steps <= steps - 1'b1;
          if (steps == STEP_W'(1)) begin
            state <= M_IDLE;
            done  <= 1'b1;
          end
        end
        M_SQRT: begin
          steps <= steps - 1'b1;
          if (steps == STEP_W'(1)) begin
            state <= M_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= M_IDLE;
        end
      endcase
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    if (state == M_IDLE && req.start) begin
      num    <= req.num;
      den    <= req.den;
      rem    <= '0;
      quot   <= '0;
      sq_v   <= SQ_W'(req.num[SQ_IN_W-1:0]);
      sq_r   <= '0;
      sq_bit <= SQ_W'(1) << (SQ_IN_W - 2);
    end else if (state == M_DIV) begin
      rem  <= rem_nx[DEN_W-1:0];
      num  <= num << 1;
      quot <= {quot[NUM_W-2:0], fits};
    end else if (state == M_SQRT) begin
      if (take) begin
        sq_v <= sq_v - trial;
      end
      sq_r   <= sq_r_next;
      sq_bit <= sq_bit >> 2;
      quot   <= NUM_W'(sq_r_next);
    end
  end

endmodule

// File: src/bnf_front.sv
// ----------------------------------------------------------------------------
// bnf_front: input queue and item classification
// Two-entry queue that tags each accepted word with the work it needs.
// ----------------------------------------------------------------------------
module bnf_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                opcode,
  input  logic [bnf_pkg::CH_W-1:0]  channel,
  input  logic [bnf_pkg::IDX_W-1:0] buffer_index,
  input  logic signed [31:0]        sample_value,
  input  logic signed [31:0]        variance_value,
  input  logic                      use_stored,
  output logic                      item_valid,
  output bnf_pkg::item_t            item,
  input  logic                      item_pop
);
  import bnf_pkg::*;

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  item_t      new_item;

  assign full       = (count == 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = slot[rd_ptr];
  assign accept     = push && !full;

  always_comb begin
    new_item.channel      = channel;
    new_item.buffer_index = buffer_index;
    new_item.sample       = sample_value;
    new_item.variance     = variance_value;
    case (op_t'(opcode))
      OP_LOAD:   new_item.kind = K_LOAD;
      OP_SAMPLE: new_item.kind = use_stored ? K_STORED : K_BATCH;
      OP_FINISH: new_item.kind = K_FINISH;
      OP_READ:   new_item.kind = K_READ;
      default:   new_item.kind = K_READ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (item_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(accept) - 2'(item_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot[wr_ptr] <= new_item;
    end
  end

endmodule

// File: src/bnf_back.sv
// ----------------------------------------------------------------------------
// bnf_back: execution sequencer of the batch normalization unit
// Runs one item at a time over the tables, the buffer and the shared math unit.
// ----------------------------------------------------------------------------
module bnf_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  bnf_pkg::item_t     item,
  output logic               item_pop,
  input  logic [15:0]        epsilon,
  input  logic [31:0]        scale_word,
  output logic               res_valid,
  output logic signed [31:0] res_value,
  output logic [2:0]         res_status,
  input  logic               res_pop
);
  import bnf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_BS_ACC, S_SS_GOT, S_SS_MDIV, S_SS_VDIV, S_NORM, S_SQRT, S_NDIV,
    S_RD_BUF, S_RD_TAB, S_RD_GOT, S_FM_RD, S_FM_GOT, S_FM_DIV, S_FM_NEXT,
    S_FV_START, S_FV_BUF, S_FV_TAB, S_FV_GOT, S_FV_MUL, S_FV_ADD,
    S_FC_RD, S_FC_GOT, S_FC_DIV, S_FC_NEXT, S_OUT
  } state_t;

  localparam logic signed [31:0] I32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] I32_MIN = 32'sh80000000;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    abs32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [32:0] abs33(input logic signed [32:0] v);
    abs33 = v[32] ? (~v + 33'd1) : v;
  endfunction

  function automatic logic signed [31:0] sat_q(input logic [NUM_W-1:0] q,
                                               input logic neg);
    if (neg) begin
      sat_q = (q > NUM_W'(33'h080000000)) ? I32_MIN : (~q[31:0] + 32'd1);
    end else begin
      sat_q = (q > NUM_W'(32'h7FFFFFFF)) ? I32_MAX : q[31:0];
    end
  endfunction

  state_t                  state;
  logic [FILL_W-1:0]       fill_count;
  logic                    batch_ready;
  logic [MAX_CHANNELS-1:0] mvalid;
  logic [MAX_CHANNELS-1:0] avalid;
  logic [CH_W-1:0]         chan_w;
  logic [FILL_W-1:0]       cnt;
  logic signed [31:0]      x_w;
  logic signed [31:0]      mean_w;
  logic signed [31:0]      var_w;
  logic signed [32:0]      diff_w;
  logic [CNT_W-1:0]        acc_cnt;
  logic [ACC_W-1:0]        acc_val;
  logic [63:0]             sq_w;
  logic                    neg;
  logic signed [31:0]      pend_value;
  status_t                 pend_status;

  // Memory ports.
  logic                mean_we, var_we, acc_we, buf_we;
  logic [CH_W-1:0]     mean_waddr, var_waddr, acc_waddr, chan_sel;
  logic [31:0]         mean_wdata, var_wdata;
  logic [ACCW_W-1:0]   acc_wdata;
  logic [IDX_W-1:0]    buf_waddr, buf_raddr;
  logic [ENTRY_W-1:0]  buf_wdata, buf_rdata;
  logic [31:0]         mean_rdata, var_rdata;
  logic [ACCW_W-1:0]   acc_rdata;

  math_req_t           m_req;
  logic                m_done;
  logic [NUM_W-1:0]    quot;

  logic signed [31:0]  mean_rd, var_rd;
  logic [CNT_W-1:0]    acc_cnt_rd;
  logic [ACC_W-1:0]    acc_val_rd;
  logic [FILL_W-1:0]   eff_fill;
  logic                last_chan;
  logic [30:0]         pos_var;
  logic [31:0]         var_eps;
  logic [64:0]         sq_rnd;
  logic [32:0]         diff_mag;

  assign item_pop  = (state == S_IDLE) && item_valid;
  assign chan_sel  = (state == S_IDLE) ? item.channel : chan_w;
  assign buf_raddr = (state == S_IDLE) ? item.buffer_index : cnt[IDX_W-1:0];
  assign eff_fill  = batch_ready ? '0 : fill_count;
  assign last_chan = (chan_w == CH_W'(MAX_CHANNELS - 1));

  // Entries never written since reset read as zero.
  assign mean_rd    = mvalid[chan_w] ? mean_rdata : '0;
  assign var_rd     = mvalid[chan_w] ? var_rdata : '0;
  assign acc_cnt_rd = avalid[chan_w] ? acc_rdata[ACCW_W-1:ACC_W] : '0;
  assign acc_val_rd = avalid[chan_w] ? acc_rdata[ACC_W-1:0] : '0;

  assign pos_var  = var_w[31] ? '0 : var_w[30:0];
  assign var_eps  = {1'b0, pos_var} + {16'd0, epsilon};
  assign sq_rnd   = {1'b0, sq_w} + 65'h8000;
  assign diff_mag = abs33(diff_w);

  always_comb begin
    mean_we    = 1'b0;
    mean_waddr = chan_w;
    mean_wdata = sat_q(quot, neg);
    var_we     = 1'b0;
    var_waddr  = chan_w;
    var_wdata  = sat_q(quot, 1'b0);
    acc_we     = 1'b0;
    acc_waddr  = chan_w;
    acc_wdata  = {acc_cnt, acc_val + ACC_W'(sq_rnd[64:16])};
    buf_we     = 1'b0;
    buf_waddr  = eff_fill[IDX_W-1:0];
    buf_wdata  = {item.channel, item.sample};
    m_req      = '0;
    m_req.op   = MOP_DIV;
    case (state)
      S_IDLE: begin
        if (item_valid && item.kind == K_LOAD) begin
          mean_we    = 1'b1;
          mean_waddr = item.channel;
          mean_wdata = item.sample;
          var_we     = 1'b1;
          var_waddr  = item.channel;
          var_wdata  = item.variance;
        end
        if (item_valid && item.kind == K_BATCH &&
            eff_fill < FILL_W'(BUFFER_DEPTH)) begin
          buf_we = 1'b1;
        end
      end
      S_BS_ACC: begin
        acc_we    = 1'b1;
        acc_wdata = {acc_cnt_rd + CNT_W'(1),
                     acc_val_rd + {{(ACC_W-32){x_w[31]}}, x_w}};
      end
      S_SS_GOT: begin
        m_req.start = (scale_word != 32'd0);
        m_req.num   = NUM_W'({abs32(mean_rd), 16'h0000});
        m_req.den   = scale_word;
      end
      S_SS_MDIV: begin
        m_req.start = m_done;
        m_req.num   = NUM_W'({abs32(var_w), 16'h0000});
        m_req.den   = scale_word;
      end
      S_NORM: begin
        m_req.start = 1'b1;
        m_req.op    = MOP_SQRT;
        m_req.num   = NUM_W'({var_eps, 16'h0000});
      end
      S_SQRT: begin
        m_req.start = m_done && (quot[D_W-1:0] != '0);
        m_req.num   = NUM_W'({diff_mag, 16'h0000});
        m_req.den   = DEN_W'(quot[D_W-1:0]);
      end
      S_FM_GOT: begin
        m_req.start = (acc_cnt_rd != '0);
        m_req.num   = acc_val_rd[ACC_W-1] ? (~acc_val_rd + ACC_W'(1)) : acc_val_rd;
        m_req.den   = DEN_W'(acc_cnt_rd);
      end
      S_FM_DIV: begin
        mean_we   = m_done;
        acc_we    = m_done;
        acc_wdata = {acc_cnt, {ACC_W{1'b0}}};
      end
      S_FV_ADD: begin
        acc_we = 1'b1;
      end
      S_FC_GOT: begin
        m_req.start = (acc_cnt_rd != '0);
        m_req.num   = acc_val_rd;
        m_req.den   = DEN_W'(acc_cnt_rd);
      end
      S_FC_DIV: begin
        var_we = m_done;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fill_count  <= '0;
      batch_ready <= 1'b0;
      mvalid      <= '0;
      avalid      <= '0;
      res_valid   <= 1'b0;
    end else begin
      // A result moving in from S_OUT refills the register in the same cycle.
      if (res_pop && state != S_OUT) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            chan_w     <= (item.kind == K_FINISH) ? '0 : item.channel;
            x_w        <= item.sample;
            pend_value <= '0;
            case (item.kind)
              K_LOAD: begin
                mvalid[item.channel] <= 1'b1;
                pend_status          <= ST_STORED;
                state                <= S_OUT;
              end
              K_STORED: begin
                state <= S_SS_GOT;
              end
              K_BATCH: begin
                batch_ready <= 1'b0;
                if (eff_fill >= FILL_W'(BUFFER_DEPTH)) begin
                  fill_count  <= eff_fill;
                  pend_status <= ST_FULL;
                  state       <= S_OUT;
                end else begin
                  fill_count <= eff_fill + FILL_W'(1);
                  state      <= S_BS_ACC;
                end
              end
              K_FINISH: begin
                state <= S_FM_RD;
              end
              K_READ: begin
                if (!batch_ready || {1'b0, item.buffer_index} >= fill_count) begin
                  pend_status <= ST_INVALID;
                  state       <= S_OUT;
                end else begin
                  state <= S_RD_BUF;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_BS_ACC: begin
          avalid[chan_w] <= 1'b1;
          pend_status    <= ST_STORED;
          state          <= S_OUT;
        end
        S_SS_GOT: begin
          neg <= mean_rd[31];
          if (scale_word == 32'd0) begin
            mean_w <= '0;
            var_w  <= '0;
            state  <= S_NORM;
          end else begin
            var_w <= var_rd;
            state <= S_SS_MDIV;
          end
        end
        S_SS_MDIV: begin
          if (m_done) begin
            mean_w <= sat_q(quot, neg);
            neg    <= var_w[31];
            state  <= S_SS_VDIV;
          end
        end
        S_SS_VDIV: begin
          if (m_done) begin
            var_w <= sat_q(quot, neg);
            state <= S_NORM;
          end
        end
        S_NORM: begin
          diff_w <= {x_w[31], x_w} - {mean_w[31], mean_w};
          state  <= S_SQRT;
        end
        S_SQRT: begin
          if (m_done) begin
            if (quot[D_W-1:0] == '0) begin
              // Zero deviation: saturate toward the sign of the difference.
              if (diff_w == '0) begin
                pend_value <= '0;
              end else begin
                pend_value <= diff_w[32] ? I32_MIN : I32_MAX;
              end
              pend_status <= ST_VALUE;
              state       <= S_OUT;
            end else begin
              neg   <= diff_w[32];
              state <= S_NDIV;
            end
          end
        end
        S_NDIV: begin
          if (m_done) begin
            pend_value  <= sat_q(quot, neg);
            pend_status <= ST_VALUE;
            state       <= S_OUT;
          end
        end
        S_RD_BUF: begin
          x_w    <= buf_rdata[31:0];
          chan_w <= buf_rdata[ENTRY_W-1:32];
          state  <= S_RD_TAB;
        end
        S_RD_TAB: begin
          state <= S_RD_GOT;
        end
        S_RD_GOT: begin
          mean_w <= mean_rd;
          var_w  <= var_rd;
          state  <= S_NORM;
        end
        S_FM_RD: begin
          state <= S_FM_GOT;
        end
        S_FM_GOT: begin
          acc_cnt <= acc_cnt_rd;
          neg     <= acc_val_rd[ACC_W-1];
          state   <= (acc_cnt_rd != '0) ? S_FM_DIV : S_FM_NEXT;
        end
        S_FM_DIV: begin
          if (m_done) begin
            mvalid[chan_w] <= 1'b1;
            state          <= S_FM_NEXT;
          end
        end
        S_FM_NEXT: begin
          if (last_chan) begin
            cnt   <= '0;
            state <= S_FV_START;
          end else begin
            chan_w <= chan_w + CH_W'(1);
            state  <= S_FM_RD;
          end
        end
        S_FV_START: begin
          if (cnt >= fill_count) begin
            chan_w <= '0;
            state  <= S_FC_RD;
          end else begin
            state <= S_FV_BUF;
          end
        end
        S_FV_BUF: begin
          x_w    <= buf_rdata[31:0];
          chan_w <= buf_rdata[ENTRY_W-1:32];
          state  <= S_FV_TAB;
        end
        S_FV_TAB: begin
          state <= S_FV_GOT;
        end
        S_FV_GOT: begin
          acc_cnt <= acc_cnt_rd;
          acc_val <= acc_val_rd;
          diff_w  <= {x_w[31], x_w} - {mean_rd[31], mean_rd};
          state   <= S_FV_MUL;
        end
        S_FV_MUL: begin
          sq_w  <= diff_mag[31:0] * diff_mag[31:0];
          state <= S_FV_ADD;
        end
        S_FV_ADD: begin
          avalid[chan_w] <= 1'b1;
          cnt            <= cnt + FILL_W'(1);
          state          <= S_FV_START;
        end
        S_FC_RD: begin
          state <= S_FC_GOT;
        end
        S_FC_GOT: begin
          state <= (acc_cnt_rd != '0) ? S_FC_DIV : S_FC_NEXT;
        end
        S_FC_DIV: begin
          if (m_done) begin
            mvalid[chan_w] <= 1'b1;
            state          <= S_FC_NEXT;
          end
        end
        S_FC_NEXT: begin
          if (last_chan) begin
            avalid      <= '0;
            batch_ready <= 1'b1;
            pend_value  <= '0;
            pend_status <= ST_FINISHED;
            state       <= S_OUT;
          end else begin
            chan_w <= chan_w + CH_W'(1);
            state  <= S_FC_RD;
          end
        end
        S_OUT: begin
          if (!res_valid || res_pop) begin
            res_valid  <= 1'b1;
            res_value  <= pend_value;
            res_status <= pend_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  bnf_math u_math (
    .clk  (clk),
    .rst  (rst),
    .req  (m_req),
    .done (m_done),
    .quot (quot)
  );

  bnf_ram #(.WIDTH(32), .DEPTH(MAX_CHANNELS)) u_mean_ram (
    .clk   (clk),
    .we    (mean_we),
    .waddr (mean_waddr),
    .wdata (mean_wdata),
    .raddr (chan_sel),
    .rdata (mean_rdata)
  );

  bnf_ram #(.WIDTH(32), .DEPTH(MAX_CHANNELS)) u_var_ram (
    .clk   (clk),
    .we    (var_we),
    .waddr (var_waddr),
    .wdata (var_wdata),
    .raddr (chan_sel),
    .rdata (var_rdata)
  );

  bnf_ram #(.WIDTH(ACCW_W), .DEPTH(MAX_CHANNELS)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (chan_sel),
    .rdata (acc_rdata)
  );

  bnf_ram #(.WIDTH(ENTRY_W), .DEPTH(BUFFER_DEPTH)) u_buf_ram (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  a_math_done_waited: assert property (@(posedge clk) disable iff (rst)
    m_done |-> (state == S_SS_MDIV || state == S_SS_VDIV || state == S_SQRT ||
                state == S_NDIV || state == S_FM_DIV || state == S_FC_DIV))
    else $error("math unit finished while no state waits for it");

  a_item_pop_idle: assert property (@(posedge clk) disable iff (rst)
    item_pop |-> (state == S_IDLE && item_valid))
    else $error("item taken outside the idle state");

  a_out_moves: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !res_valid) |=> (res_valid && state == S_IDLE))
    else $error("pending result did not move to the output register");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    $rose(batch_ready) |-> (avalid == '0))
    else $error("channel sums not cleared at end of batch");

endmodule
